[rtl/opp_pkg.sv]
package opp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int TOKEN_W  = 3;
    localparam int SYM_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [SYM_W-1:0] SYM_ID    = 2'd0;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_TIMES = 2'd2;
    localparam logic [SYM_W-1:0] SYM_END   = 2'd3;

    localparam logic [TOKEN_W-1:0] TOKEN_LAST = {1'b0, SYM_END};

    localparam logic [1:0] REL_ERROR   = 2'd0;
    localparam logic [1:0] REL_LESS    = 2'd1;
    localparam logic [1:0] REL_GREATER = 2'd2;
    localparam logic [1:0] REL_EQUAL   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_SHIFT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [PADDR_W-1:0] ADDR_PRECEDENCE_TABLE = 3'd0;
    localparam logic [DATA_W-1:0]  TABLE_RESET           = 32'd363436456;

    localparam logic [IDX_W-1:0] TOP_FULL = IDX_W'(STACK_DEPTH - 1);

    function automatic logic [1:0] relation(
        input logic [DATA_W-1:0] tbl,
        input logic [SYM_W-1:0]  top_sym,
        input logic [SYM_W-1:0]  in_sym
    );
        logic [4:0] bit_pos;
        bit_pos = {top_sym, in_sym, 1'b0};
        return tbl[bit_pos +: 2];
    endfunction

endpackage

[rtl/opp_token_if.sv]
interface opp_token_if;
    logic                         valid;
    logic                         ready;
    logic [opp_pkg::TOKEN_W-1:0]  token;

    modport source (output valid, output token, input ready);
    modport sink (input valid, input token, output ready);
endinterface

[rtl/opp_result_if.sv]
interface opp_result_if;
    logic                          valid;
    logic                          ready;
    logic [opp_pkg::STATUS_W-1:0]  status;
    logic [opp_pkg::COUNT_W-1:0]   reduction_count;

    modport source (output valid, output status, output reduction_count, input ready);
    modport sink (input valid, input status, input reduction_count, output ready);
endinterface

[rtl/opp_ram.sv]
module opp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/operator_precedence_parser_core.sv]
// Operator-precedence recognizer for id, plus, times and the end marker, one token per item
// and exactly one result item per token. The terminal stack sits in a one-port-read,
// one-port-write RAM; the top symbol is held in a register and the bottom end marker is
// implied, so no clearing pass is needed after reset or after accept/reject. A token that
// shifts, accepts or rejects without reducing goes through accept, evaluate and result;
// the result step waits for a free output register. Each reduction adds an evaluate step
// and a pop step per symbol popped, as each pop waits on the registered RAM read of the
// entry below; one off the stack bottom ends the token instead. A finished result waits in an
// output register; the next token is taken as soon as that result is loaded there. The
// precedence table is register 0 on the APB port and should only be written while the
// block is idle.
module operator_precedence_parser_core (
    input  logic                           clk,
    input  logic                           rst_n,
    opp_token_if.sink                      tokens,
    opp_result_if.source                   results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [opp_pkg::PADDR_W-1:0]    paddr,
    input  logic [opp_pkg::DATA_W-1:0]     pwdata,
    output logic [opp_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_POP    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [opp_pkg::DATA_W-1:0]      table_reg;
    logic [opp_pkg::TOKEN_W-1:0]     tok_reg, tok_next;
    logic [opp_pkg::IDX_W-1:0]       top_reg, top_next;
    logic [opp_pkg::SYM_W-1:0]       top_sym_reg, top_sym_next;
    logic [opp_pkg::SYM_W-1:0]       popped_reg, popped_next;
    logic [opp_pkg::COUNT_W-1:0]     count_reg, count_next, count_inc;
    logic [opp_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                            res_valid_reg, res_valid_next;
    logic [opp_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [opp_pkg::COUNT_W-1:0]     res_count_reg, res_count_next;

    logic                            ram_we, ram_re;
    logic [opp_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [opp_pkg::SYM_W-1:0]       ram_rdata;
    logic [opp_pkg::SYM_W-1:0]       below_sym;
    logic [1:0]                      rel_top, rel_below;
    logic                            slot_free;
    logic                            cfg_write;

    opp_ram #(
        .WIDTH (opp_pkg::SYM_W),
        .DEPTH (opp_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tok_reg[opp_pkg::SYM_W-1:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == opp_pkg::ADDR_PRECEDENCE_TABLE);
    assign prdata    = (paddr == opp_pkg::ADDR_PRECEDENCE_TABLE) ? table_reg
                                                                 : '0;

    // entry zero is always the end marker
    assign below_sym = (top_reg == '0) ? opp_pkg::SYM_END : ram_rdata;
    assign rel_top   = opp_pkg::relation(table_reg, top_sym_reg,
                                         tok_reg[opp_pkg::SYM_W-1:0]);
    assign rel_below = opp_pkg::relation(table_reg, below_sym, popped_reg);
    assign count_inc = (count_reg == opp_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;
    assign slot_free = !res_valid_reg || results.ready;

    assign tokens.ready           = (state_reg == S_IDLE);
    assign results.valid          = res_valid_reg;
    assign results.status         = res_status_reg;
    assign results.reduction_count = res_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        tok_next        = tok_reg;
        top_next        = top_reg;
        top_sym_next    = top_sym_reg;
        popped_next     = popped_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        res_valid_next  = res_valid_reg && !results.ready;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = top_reg + 1'b1;
        ram_re          = 1'b0;
        ram_raddr       = top_reg - 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (tokens.valid)
                begin
                    tok_next   = tokens.token;
                    count_next = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (tok_reg > opp_pkg::TOKEN_LAST)
                begin
                    status_next = opp_pkg::ST_REJECT;
                    state_next  = S_FINISH;
                end
                else if (top_reg == '0 && tok_reg == opp_pkg::TOKEN_LAST)
                begin
                    status_next = opp_pkg::ST_ACCEPT;
                    state_next  = S_FINISH;
                end
                else if (rel_top == opp_pkg::REL_GREATER)
                begin
                    if (top_reg == '0)
                    begin
                        count_next  = count_inc;
                        status_next = opp_pkg::ST_REJECT;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        // pop the top, fetch the entry below it
                        popped_next = top_sym_reg;
                        top_next    = top_reg - 1'b1;
                        ram_re      = 1'b1;
                        state_next  = S_POP;
                    end
                end
                else if (rel_top == opp_pkg::REL_ERROR)
                begin
                    status_next = opp_pkg::ST_REJECT;
                    state_next  = S_FINISH;
                end
                else if (top_reg == opp_pkg::TOP_FULL)
                begin
                    status_next = opp_pkg::ST_OVERFLOW;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ram_we       = 1'b1;
                    top_next     = top_reg + 1'b1;
                    top_sym_next = tok_reg[opp_pkg::SYM_W-1:0];
                    status_next  = opp_pkg::ST_SHIFT;
                    state_next   = S_FINISH;
                end
            end
            S_POP:
            begin
                if (rel_below == opp_pkg::REL_LESS)
                begin
                    // reduction done, look at the token again
                    count_next   = count_inc;
                    top_sym_next = below_sym;
                    state_next   = S_EVAL;
                end
                else if (top_reg == '0)
                begin
                    count_next  = count_inc;
                    status_next = opp_pkg::ST_REJECT;
                    state_next  = S_FINISH;
                end
                else
                begin
                    popped_next = below_sym;
                    top_next    = top_reg - 1'b1;
                    ram_re      = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_count_next  = count_reg;
                    if (status_reg != opp_pkg::ST_SHIFT)
                    begin
                        top_next     = '0;
                        top_sym_next = opp_pkg::SYM_END;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            table_reg     <= opp_pkg::TABLE_RESET;
            top_reg       <= '0;
            top_sym_reg   <= opp_pkg::SYM_END;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            top_sym_reg   <= top_sym_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                table_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg        <= tok_next;
        popped_reg     <= popped_next;
        status_reg     <= status_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

endmodule
